// ----- rtl/core/bmpc_pkg.sv -----
package bmpc_pkg;

    // Header bytes held before the header can be decoded
    localparam int HOLD_LEN   = 30;
    localparam int HOLD_WORDS = HOLD_LEN / 2;

    // Default for the width/height range check
    localparam int DIM_BITS_DEF = 16;

    localparam logic [15:0] BPP_IN  = 16'd24;
    localparam logic [15:0] BPP_OUT = 16'd16;

    // Word indexes inside the held header (byte position / 2)
    localparam logic [3:0] W_FSIZE_LO = 4'd1;
    localparam logic [3:0] W_FSIZE_HI = 4'd2;
    localparam logic [3:0] W_OFF_LO   = 4'd5;
    localparam logic [3:0] W_OFF_HI   = 4'd6;
    localparam logic [3:0] W_WID_LO   = 4'd9;
    localparam logic [3:0] W_WID_HI   = 4'd10;
    localparam logic [3:0] W_HGT_LO   = 4'd11;
    localparam logic [3:0] W_HGT_HI   = 4'd12;
    localparam logic [3:0] W_BPP      = 4'd14;

    // Byte positions (odd, high byte) of the image size words past the hold
    localparam logic [31:0] POS_ISIZE_LO_HI = 32'd35;
    localparam logic [31:0] POS_ISIZE_HI_HI = 32'd37;

    // Pixel field positions in the 16-bit word
    localparam int GREEN_LSB = 6;
    localparam int RED_LSB   = 6 + 5;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } in_word_t;

    typedef struct packed {
        logic [15:0] out_word;
        logic        last_word;
        logic        unsupported;
    } res_word_t;

    function automatic logic [15:0] pack_pixel(input logic [4:0] blue,
                                               input logic [4:0] green,
                                               input logic [4:0] red);
        logic [15:0] w;
        w = '0;
        w[4:0]                 = blue;
        w[GREEN_LSB +: 5]      = green;
        w[RED_LSB +: 5]        = red;
        return w;
    endfunction

endpackage

// ----- rtl/core/bmp_24bit_to_16bit_converter.sv -----
// 24-bit to 16-bit BMP converter (5-bit blue, green, red at bits 4:0, 10:6,
// 15:11). Takes the file one byte per word on the s_ channel and returns
// 16-bit little-endian words on the m_ channel. Bytes 0-29 are held, then
// width, height, data offset and bit count are decoded; a file that is not
// 24-bit, has width/height at or above 2^DIM_BITS, or an odd data offset or
// one below 30 yields a single word with m_unsupported and m_last_word set,
// and the rest of the file is dropped. Otherwise the header comes back with
// file size, bit count and image size patched, followed by one word per
// blue/green/red triple (source row padding skipped, none added).
// s_start_of_file restarts the block on that byte. Rate: one byte per clock
// in the header tail and pixel data while m_ready holds. After byte 29 the
// input stalls for the width*height multiply, the file size add and the 15
// held header words, which leave through the single result register one per
// clock while m_ready holds. Bytes pass the input and result registers.
module bmp_24bit_to_16bit_converter
    import bmpc_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_word,
    output logic        m_last_word,
    output logic        m_unsupported
);

    in_word_t  s_word;
    in_word_t  in_word;
    logic      in_valid;
    logic      in_take;
    res_word_t res;
    res_word_t m_word;
    logic      res_valid;
    logic      res_ready;

    assign s_word.file_byte     = s_file_byte;
    assign s_word.start_of_file = s_start_of_file;

    // Input register: holds one byte until the parser takes it
    bmpc_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .take    (in_take),
        .valid   (in_valid),
        .word    (in_word)
    );

    // Header decode, patching, header burst and pixel packing
    bmpc_parse #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .in_take   (in_take),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Result register: a finished word waits here until m_ready takes it
    bmpc_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_word  (res),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    assign m_out_word    = m_word.out_word;
    assign m_last_word   = m_word.last_word;
    assign m_unsupported = m_word.unsupported;

endmodule

// ----- rtl/core/bmpc_in_reg.sv -----
module bmpc_in_reg
    import bmpc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_word,
    input  logic     take,
    output logic     valid,
    output in_word_t word
);

    logic     valid_reg;
    in_word_t word_reg;

    assign s_ready = !valid_reg || take;
    assign valid   = valid_reg;
    assign word    = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

// ----- rtl/core/bmpc_out_reg.sv -----
module bmpc_out_reg
    import bmpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  res_word_t push_word,
    output logic      m_valid,
    input  logic      m_ready,
    output res_word_t m_word
);

    logic      valid_reg;
    res_word_t word_reg;

    assign push_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_word     = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid && push_ready) begin
            word_reg <= push_word;
        end
    end

endmodule

// ----- rtl/core/bmpc_parse.sv -----
module bmpc_parse
    import bmpc_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  in_word_t  in_word,
    output logic      in_take,
    output logic      res_valid,
    input  logic      res_ready,
    output res_word_t res
);

    typedef enum logic [2:0] {
        PH_BUFFER, PH_CALC, PH_SUM, PH_BURST,
        PH_HEADER, PH_PIXELS, PH_PAD, PH_DONE
    } phase_t;

    phase_t              state_reg, state_next, eff_state, enter_state;
    logic [31:0]         pos_reg, pos_next, eff_pos, pos_inc;
    logic [3:0]          burst_reg, burst_next;
    logic [1:0]          pix_phase_reg, pix_phase_next;
    logic [1:0]          pad_reg, pad_next;
    logic [DIM_BITS-1:0] col_reg, col_next, row_reg, row_next;

    logic [15:0]         hold_reg [HOLD_WORDS];
    logic                hold_we;
    logic [DIM_BITS-1:0] width_reg, width_next, height_reg, height_next;
    logic [31:0]         off_reg, off_next;
    logic [31:0]         img_bytes_reg, img_bytes_next;
    logic [31:0]         fsize_reg, fsize_next;
    logic [7:0]          low_reg, low_next;
    logic [4:0]          blue_reg, blue_next, green_reg, green_next;
    logic                no_pix_reg, no_pix_next;

    logic [7:0]          b;
    logic [31:0]         dec_w, dec_h, dec_off, prod;
    logic [15:0]         dec_bpp, burst_word;
    logic                dec_bad, end_row, end_img;

    assign b           = in_word.file_byte;
    assign eff_state   = in_word.start_of_file ? PH_BUFFER : state_reg;
    assign eff_pos     = in_word.start_of_file ? '0 : pos_reg;
    assign pos_inc     = eff_pos + 32'd1;
    assign enter_state = no_pix_reg ? PH_DONE : PH_PIXELS;

    // header fields, byte 29 is the incoming byte
    assign dec_w   = {hold_reg[W_WID_HI], hold_reg[W_WID_LO]};
    assign dec_h   = {hold_reg[W_HGT_HI], hold_reg[W_HGT_LO]};
    assign dec_off = {hold_reg[W_OFF_HI], hold_reg[W_OFF_LO]};
    assign dec_bpp = {b, hold_reg[W_BPP][7:0]};
    assign dec_bad = (dec_bpp != BPP_IN) || ((dec_w >> DIM_BITS) != 32'd0)
                  || ((dec_h >> DIM_BITS) != 32'd0) || dec_off[0]
                  || (dec_off < 32'(HOLD_LEN));

    assign prod       = 32'(width_reg) * 32'(height_reg);
    assign burst_word = hold_reg[burst_reg];

    assign end_row = (col_reg == width_reg - DIM_BITS'(1));
    assign end_img = end_row && (row_reg == height_reg - DIM_BITS'(1));

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        burst_next     = burst_reg;
        pix_phase_next = pix_phase_reg;
        pad_next       = pad_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        off_next       = off_reg;
        img_bytes_next = img_bytes_reg;
        fsize_next     = fsize_reg;
        low_next       = low_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        no_pix_next    = no_pix_reg;
        hold_we        = 1'b0;
        in_take        = 1'b0;
        res_valid      = 1'b0;
        res            = '0;

        unique case (state_reg)
            PH_CALC: begin
                img_bytes_next = {prod[30:0], 1'b0};
                state_next     = PH_SUM;
            end
            PH_SUM: begin
                fsize_next = img_bytes_reg + off_reg;
                burst_next = '0;
                state_next = PH_BURST;
            end
            PH_BURST: begin
                if (res_ready) begin
                    res_valid    = 1'b1;
                    res.out_word = burst_word;
                    if (burst_reg == W_FSIZE_LO) res.out_word = fsize_reg[15:0];
                    if (burst_reg == W_FSIZE_HI) res.out_word = fsize_reg[31:16];
                    if (burst_reg == W_BPP)      res.out_word = BPP_OUT;
                    res.last_word = (burst_reg == 4'(HOLD_WORDS - 1))
                                 && (off_reg == 32'(HOLD_LEN)) && no_pix_reg;
                    if (burst_reg == 4'(HOLD_WORDS - 1)) begin
                        state_next = (off_reg == 32'(HOLD_LEN)) ? enter_state : PH_HEADER;
                    end else begin
                        burst_next = burst_reg + 4'd1;
                    end
                end
            end
            default: begin
                if (in_valid && res_ready) begin
                    in_take = 1'b1;
                    unique case (eff_state)
                        PH_BUFFER: begin
                            hold_we    = 1'b1;
                            pos_next   = pos_inc;
                            state_next = PH_BUFFER;
                            if (eff_pos == 32'(HOLD_LEN - 1)) begin
                                if (dec_bad) begin
                                    res_valid       = 1'b1;
                                    res.last_word   = 1'b1;
                                    res.unsupported = 1'b1;
                                    state_next      = PH_DONE;
                                end else begin
                                    width_next     = dec_w[DIM_BITS-1:0];
                                    height_next    = dec_h[DIM_BITS-1:0];
                                    off_next       = dec_off;
                                    no_pix_next    = (dec_w == 32'd0) || (dec_h == 32'd0);
                                    pix_phase_next = '0;
                                    col_next       = '0;
                                    row_next       = '0;
                                    pad_next       = '0;
                                    state_next     = PH_CALC;
                                end
                            end
                        end
                        PH_HEADER: begin
                            if (pos_reg[0]) begin
                                res_valid    = 1'b1;
                                res.out_word = {b, low_reg};
                                if (pos_reg == POS_ISIZE_LO_HI) begin
                                    res.out_word = img_bytes_reg[15:0];
                                end
                                if (pos_reg == POS_ISIZE_HI_HI) begin
                                    res.out_word = img_bytes_reg[31:16];
                                end
                                res.last_word = (pos_inc == off_reg) && no_pix_reg;
                            end else begin
                                low_next = b;
                            end
                            pos_next = pos_inc;
                            if (pos_inc == off_reg) begin
                                state_next = enter_state;
                            end
                        end
                        PH_PIXELS: begin
                            case (pix_phase_reg)
                                2'd0: begin
                                    blue_next      = b[7:3];
                                    pix_phase_next = 2'd1;
                                end
                                2'd1: begin
                                    green_next     = b[7:3];
                                    pix_phase_next = 2'd2;
                                end
                                default: begin
                                    res_valid      = 1'b1;
                                    res.out_word   = pack_pixel(blue_reg, green_reg, b[7:3]);
                                    res.last_word  = end_img;
                                    pix_phase_next = 2'd0;
                                    if (end_img) begin
                                        state_next = PH_DONE;
                                    end else if (end_row) begin
                                        col_next = '0;
                                        row_next = row_reg + DIM_BITS'(1);
                                        // source rows pad to 4 bytes: pad = width mod 4
                                        pad_next = width_reg[1:0];
                                        if (width_reg[1:0] != 2'd0) begin
                                            state_next = PH_PAD;
                                        end
                                    end else begin
                                        col_next = col_reg + DIM_BITS'(1);
                                    end
                                end
                            endcase
                        end
                        PH_PAD: begin
                            pad_next = pad_reg - 2'd1;
                            if (pad_reg == 2'd1) begin
                                state_next = PH_PIXELS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PH_BUFFER;
            pos_reg       <= '0;
            burst_reg     <= '0;
            pix_phase_reg <= '0;
            pad_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            burst_reg     <= burst_next;
            pix_phase_reg <= pix_phase_next;
            pad_reg       <= pad_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_we) begin
            if (eff_pos[0]) begin
                hold_reg[eff_pos[4:1]][15:8] <= b;
            end else begin
                hold_reg[eff_pos[4:1]][7:0] <= b;
            end
        end
        width_reg     <= width_next;
        height_reg    <= height_next;
        off_reg       <= off_next;
        img_bytes_reg <= img_bytes_next;
        fsize_reg     <= fsize_next;
        low_reg       <= low_next;
        blue_reg      <= blue_next;
        green_reg     <= green_next;
        no_pix_reg    <= no_pix_next;
    end

    a_calc_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PH_CALC || state_reg == PH_SUM) |-> (!res_valid && !in_take))
        else $error("result or byte taken during size arithmetic");

    a_burst_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PH_BURST) |-> !in_take)
        else $error("byte taken during header burst");

    a_unsup_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.unsupported) |-> res.last_word)
        else $error("reject word without last flag");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.last_word) |=> (state_reg == PH_DONE))
        else $error("stream continues after last word");

endmodule
